[hw/rtl/time_sliced_servo_pwm_assert.svh]
// ----------------------------------------------------------------------------
// Servo PWM assertion macros
// Shared property macros for the time-sliced servo PWM generator.
// ----------------------------------------------------------------------------
`ifndef TIME_SLICED_SERVO_PWM_ASSERT_SVH
`define TIME_SLICED_SERVO_PWM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("servo pwm check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("servo pwm check failed");

`endif

[hw/rtl/tssp_pkg.sv]
// ----------------------------------------------------------------------------
// tssp_pkg
// Types and constants shared by the time-sliced servo PWM generator.
// ----------------------------------------------------------------------------
package tssp_pkg;

    localparam int SERVO_COUNT = 8;

    localparam int CNT_W   = 16;
    localparam int PULSE_W = 16;
    localparam int STEP_W  = 8;
    localparam int IDX_W   = 8;
    localparam int ANGLE_W = 8;
    localparam int PIN_W   = 8;
    localparam int CUR_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]   RST_SLOT_PERIOD = 16'd60000;
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 16'd1500;
    localparam logic [STEP_W-1:0]  RST_DEGREE_STEP = 8'd32;
    localparam logic [PULSE_W-1:0] RST_PULSE_WIDTH = 16'd1000;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    // Pins that exist; the rest are tied low.
    localparam logic [PIN_W-1:0] CHAN_MASK = PIN_W'((1 << SERVO_COUNT) - 1);

    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_SET_ANGLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_PERIOD = 2'd0,
        CFG_MIN_PULSE   = 2'd1,
        CFG_DEGREE_STEP = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic               ok;
        logic [PULSE_W-1:0] width;
    } t_pulse_req;

endpackage

[hw/rtl/tssp_pulse_calc.sv]
// ----------------------------------------------------------------------------
// tssp_pulse_calc
// Checks a set-angle command and turns the angle into a saturated pulse width.
// ----------------------------------------------------------------------------
module tssp_pulse_calc (
    input  logic [tssp_pkg::IDX_W-1:0]   i_servo_index,
    input  logic [tssp_pkg::ANGLE_W-1:0] i_angle_deg,
    input  logic [tssp_pkg::PULSE_W-1:0] i_min_pulse,
    input  logic [tssp_pkg::STEP_W-1:0]  i_degree_step,
    output tssp_pkg::t_pulse_req         o_req
);

    localparam int PROD_W = tssp_pkg::ANGLE_W + tssp_pkg::STEP_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic              idx_ok;
    logic              ang_ok;

    assign prod   = PROD_W'(i_angle_deg) * PROD_W'(i_degree_step);
    assign sum    = SUM_W'(i_min_pulse) + SUM_W'(prod);
    assign idx_ok = 9'(i_servo_index) < 9'(tssp_pkg::SERVO_COUNT);
    assign ang_ok = i_angle_deg <= tssp_pkg::MAX_ANGLE;

    always_comb begin
        o_req.ok = idx_ok && ang_ok;
        // saturate to the widest pulse the counter can reach
        if (sum[SUM_W-1:tssp_pkg::PULSE_W] != '0) begin
            o_req.width = '1;
        end else begin
            o_req.width = sum[tssp_pkg::PULSE_W-1:0];
        end
    end

endmodule

[hw/rtl/time_sliced_servo_pwm.sv]
// ----------------------------------------------------------------------------
// time_sliced_servo_pwm
// Time-multiplexed servo pulse generator with a stream in and a stream out.
// ----------------------------------------------------------------------------
// Each input beat is a timer tick (tuser = 0) or a set-angle command
// (tuser = 1); each gives exactly one output beat with all pin levels and the
// slot_start / accepted flags. The block takes one beat per clock: a beat is
// registered on entry, worked by combinational logic and placed in the output
// register, so throughput is one beat per cycle as long as the output side is
// ready. The config port is always ready and must be written only while no
// beats are in flight.
// ----------------------------------------------------------------------------
module time_sliced_servo_pwm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [7:0] servo_index, [15:8] angle_deg
    input  logic                              s_axis_tuser,  // [0] command
    // stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] pin_levels
    output logic [1:0]                        m_axis_tuser,  // [0] slot_start, [1] accepted
    // config writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tssp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tssp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CNT_W   = tssp_pkg::CNT_W;
    localparam int PULSE_W = tssp_pkg::PULSE_W;
    localparam int CUR_W   = tssp_pkg::CUR_W;
    localparam int PIN_W   = tssp_pkg::PIN_W;

    // config registers
    logic [CNT_W-1:0]            r_slot_period;
    logic [PULSE_W-1:0]          r_min_pulse;
    logic [tssp_pkg::STEP_W-1:0] r_degree_step;

    // input stage
    logic                         r_in_valid;
    logic                         r_in_cmd;
    logic [tssp_pkg::IDX_W-1:0]   r_in_idx;
    logic [tssp_pkg::ANGLE_W-1:0] r_in_angle;

    // generator state
    logic [CNT_W-1:0]   r_slot_counter;
    logic [CUR_W-1:0]   r_cursor;
    logic [PULSE_W-1:0] r_pulse_widths [tssp_pkg::SERVO_COUNT];
    logic [PULSE_W-1:0] r_compare;
    logic [PIN_W-1:0]   r_pins;

    // output stage
    logic               r_out_valid;
    logic [PIN_W-1:0]   r_out_pins;
    logic               r_out_slot_start;
    logic               r_out_accepted;

    logic               advance;
    logic               tick;
    logic               set_cmd;
    logic               wrap;
    logic [CUR_W:0]     cur_inc;
    logic [CNT_W-1:0]   n_slot_counter;
    logic [CUR_W-1:0]   n_cursor;
    logic [PULSE_W-1:0] n_compare;
    logic [PIN_W-1:0]   n_pins;
    logic [PIN_W-1:0]   cur_bit;

    tssp_pkg::t_pulse_req pulse_req;

    tssp_pulse_calc u_pulse_calc (
        .i_servo_index (r_in_idx),
        .i_angle_deg   (r_in_angle),
        .i_min_pulse   (r_min_pulse),
        .i_degree_step (r_degree_step),
        .o_req         (pulse_req)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign tick    = advance && r_in_valid && (r_in_cmd == tssp_pkg::CMD_TICK);
    assign set_cmd = advance && r_in_valid && (r_in_cmd == tssp_pkg::CMD_SET_ANGLE);

    assign wrap    = r_slot_counter >= r_slot_period;
    assign cur_inc = {1'b0, r_cursor} + (CUR_W+1)'(1);

    always_comb begin
        n_slot_counter = r_slot_counter + CNT_W'(1);
        n_cursor       = r_cursor;
        n_compare      = r_compare;
        n_pins         = r_pins;
        if (wrap) begin
            n_slot_counter = '0;
            if (cur_inc >= (CUR_W+1)'(tssp_pkg::SERVO_COUNT)) begin
                n_cursor = '0;
            end else begin
                n_cursor = cur_inc[CUR_W-1:0];
            end
        end
        cur_bit = PIN_W'(1) << n_cursor;
        if (wrap) begin
            n_pins    = n_pins | cur_bit;
            n_compare = r_pulse_widths[n_cursor];
        end
        // compare runs on the new count, after a possible set on wrap
        if (n_slot_counter == n_compare) begin
            n_pins = n_pins & ~cur_bit;
        end
        n_pins = n_pins & tssp_pkg::CHAN_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_period  <= tssp_pkg::RST_SLOT_PERIOD;
            r_min_pulse    <= tssp_pkg::RST_MIN_PULSE;
            r_degree_step  <= tssp_pkg::RST_DEGREE_STEP;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_slot_counter <= '0;
            r_cursor       <= '0;
            r_compare      <= '0;
            r_pins         <= '0;
            for (int i = 0; i < tssp_pkg::SERVO_COUNT; i++) begin
                r_pulse_widths[i] <= tssp_pkg::RST_PULSE_WIDTH;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tssp_pkg::CFG_SLOT_PERIOD: r_slot_period <= i_cfg_data;
                    tssp_pkg::CFG_MIN_PULSE:   r_min_pulse   <= i_cfg_data;
                    tssp_pkg::CFG_DEGREE_STEP: r_degree_step <= i_cfg_data[tssp_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end

            if (tick) begin
                r_slot_counter <= n_slot_counter;
                r_cursor       <= n_cursor;
                r_compare      <= n_compare;
                r_pins         <= n_pins;
            end
            if (set_cmd && pulse_req.ok) begin
                r_pulse_widths[r_in_idx[CUR_W-1:0]] <= pulse_req.width;
            end
        end

        // payload registers
        if (s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_idx   <= s_axis_tdata[7:0];
            r_in_angle <= s_axis_tdata[15:8];
        end
        if (advance) begin
            r_out_pins       <= (r_in_cmd == tssp_pkg::CMD_TICK) ? n_pins : r_pins;
            r_out_slot_start <= (r_in_cmd == tssp_pkg::CMD_TICK) && wrap;
            r_out_accepted   <= (r_in_cmd == tssp_pkg::CMD_SET_ANGLE) && pulse_req.ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pins;
    assign m_axis_tuser  = {r_out_accepted, r_out_slot_start};

`include "time_sliced_servo_pwm_assert.svh"

    `TSSP_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `TSSP_ASSERT_NEXT(a_wrap_clears_count, i_clk, i_rst_n, tick && wrap, r_slot_counter == '0)
    `TSSP_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, 1'b1, 32'(r_cursor) < 32'(tssp_pkg::SERVO_COUNT))
    `TSSP_ASSERT_NEXT(a_set_stores, i_clk, i_rst_n, set_cmd && pulse_req.ok, r_pulse_widths[$past(r_in_idx[CUR_W-1:0])] == $past(pulse_req.width))

endmodule

[tb/time_sliced_servo_pwm_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_sliced_servo_pwm_tb
// Self-checking regression for the time-sliced servo PWM generator. Ticks and
// set-angle commands stream in with random gaps and output stalls; a predictor
// tracks slot counter, channel cursor, stored pulse widths and pin levels, and
// every output beat is compared against it field by field.
// ----------------------------------------------------------------------------
module time_sliced_servo_pwm_tb;

    localparam int CLK_PERIOD = 20;
    localparam int MAX_SHOWN  = 10;

    localparam int SERVO_COUNT = tssp_pkg::SERVO_COUNT;
    localparam int CNT_W       = tssp_pkg::CNT_W;
    localparam int PULSE_W     = tssp_pkg::PULSE_W;
    localparam int STEP_W      = tssp_pkg::STEP_W;
    localparam int IDX_W       = tssp_pkg::IDX_W;
    localparam int ANGLE_W     = tssp_pkg::ANGLE_W;
    localparam int PIN_W       = tssp_pkg::PIN_W;
    localparam int CUR_W       = tssp_pkg::CUR_W;
    localparam int CFG_IDX_W   = tssp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = tssp_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [PIN_W-1:0] pins;
        logic             slot_start;
        logic             accepted;
    } t_servo_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // [7:0] servo_index, [15:8] angle_deg
    logic                  s_axis_tuser;   // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // [7:0] pin_levels
    logic [1:0]            m_axis_tuser;   // [0] slot_start, [1] accepted
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state
    logic [CNT_W-1:0]   period_cfg;
    logic [PULSE_W-1:0] min_pulse_cfg;
    logic [STEP_W-1:0]  step_cfg;
    logic [CNT_W-1:0]   tick_count;
    logic [CUR_W-1:0]   slot_chan;
    logic [PULSE_W-1:0] chan_width [SERVO_COUNT];
    logic [PULSE_W-1:0] cmp_value;
    logic [PIN_W-1:0]   pin_mirror;

    t_servo_out pending_levels [$];
    int         fault_count;
    int         hold_request;
    bit         tx_idle_on;
    bit         rx_idle_on;

    time_sliced_servo_pwm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void servo_clear();
        period_cfg    = tssp_pkg::RST_SLOT_PERIOD;
        min_pulse_cfg = tssp_pkg::RST_MIN_PULSE;
        step_cfg      = tssp_pkg::RST_DEGREE_STEP;
        tick_count    = '0;
        slot_chan     = '0;
        cmp_value     = '0;
        pin_mirror    = '0;
        for (int i = 0; i < SERVO_COUNT; i++) chan_width[i] = tssp_pkg::RST_PULSE_WIDTH;
    endfunction

    // Advance the pin-level predictor by one beat and return the expected output.
    function automatic t_servo_out servo_next_levels(input logic cmd,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [ANGLE_W-1:0] ang);
        t_servo_out  r;
        int unsigned w;
        r = '0;
        if (cmd == tssp_pkg::CMD_TICK) begin
            if (tick_count >= period_cfg) begin
                tick_count = '0;
                slot_chan  = slot_chan + 1'b1;
                if (slot_chan >= SERVO_COUNT) slot_chan = '0;
                pin_mirror[slot_chan] = 1'b1;
                cmp_value    = chan_width[slot_chan];
                r.slot_start = 1'b1;
            end else begin
                tick_count = tick_count + 1'b1;
            end
            // compare runs on the new count, after the wrap has raised the pin
            if (tick_count == cmp_value) pin_mirror[slot_chan] = 1'b0;
            pin_mirror = pin_mirror & tssp_pkg::CHAN_MASK;
        end else if (idx < SERVO_COUNT && ang <= tssp_pkg::MAX_ANGLE) begin
            w = int'(min_pulse_cfg) + int'(ang) * int'(step_cfg);
            if (w > 32'hFFFF) w = 32'hFFFF;
            chan_width[idx[CUR_W-1:0]] = PULSE_W'(w);
            r.accepted = 1'b1;
        end
        r.pins = pin_mirror;
        return r;
    endfunction

    task automatic note_fault(input string what, input t_servo_out want,
                              input t_servo_out got);
        string want_s;
        string got_s;
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
            want_s = $sformatf("pins=%02h start=%0b acc=%0b",
                               want.pins, want.slot_start, want.accepted);
            got_s  = $sformatf("pins=%02h start=%0b acc=%0b",
                               got.pins, got.slot_start, got.accepted);
            $display("%0t ERROR %s: expected %s, got %s", $time, what, want_s, got_s);
        end
    endtask

    // Offer one beat; predict it once tready is seen high, before the edge that takes it.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [ANGLE_W-1:0] ang);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ang, idx};
        s_axis_tuser  <= cmd;
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        pending_levels.push_back(servo_next_levels(cmd, idx, ang));
        @(posedge i_clk);
    endtask

    task automatic send_random_beat();
        logic [IDX_W-1:0]   idx;
        logic [ANGLE_W-1:0] ang;
        idx = IDX_W'($urandom);
        ang = ANGLE_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            send_item(tssp_pkg::CMD_TICK, idx, ang);
        end else begin
            // mostly well-formed commands, small angles keep pulses inside the slot
            if ($urandom_range(0, 4) != 0) begin
                idx = IDX_W'($urandom_range(0, SERVO_COUNT - 1));
                ang = ($urandom_range(0, 1) == 1) ? ANGLE_W'($urandom_range(0, 12))
                                                  : ANGLE_W'($urandom_range(0, 180));
            end
            send_item(tssp_pkg::CMD_SET_ANGLE, idx, ang);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_levels.size() != 0);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        case (idx)
            tssp_pkg::CFG_SLOT_PERIOD: period_cfg    = data;
            tssp_pkg::CFG_MIN_PULSE:   min_pulse_cfg = data;
            tssp_pkg::CFG_DEGREE_STEP: step_cfg      = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop the stream, drain, then program all three registers.
    task automatic set_config(input logic [CNT_W-1:0] period,
                              input logic [PULSE_W-1:0] min_pulse,
                              input logic [STEP_W-1:0] step);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_beat(tssp_pkg::CFG_SLOT_PERIOD, period);
        cfg_beat(tssp_pkg::CFG_MIN_PULSE, min_pulse);
        // upper data bits carry junk; the register keeps only the low byte
        cfg_beat(tssp_pkg::CFG_DEGREE_STEP, {8'($urandom), step});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        repeat (3) send_item(tssp_pkg::CMD_TICK, 8'hFF, 8'hFF);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd0, 8'd0);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd7, tssp_pkg::MAX_ANGLE);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd8, 8'd0);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd255, 8'd255);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd3, tssp_pkg::MAX_ANGLE + 8'd1);
        repeat (2) send_item(tssp_pkg::CMD_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_period_extremes();
        // zero period wraps on every tick; zero width gives no pulse at all
        set_config(16'd0, 16'd0, 8'd0);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd1, 8'd0);
        repeat (4) send_item(tssp_pkg::CMD_TICK, 8'h5A, 8'hA5);
        // widest settings saturate the stored pulse width
        set_config(16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd2, tssp_pkg::MAX_ANGLE);
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd4, 8'd0);
        repeat (2) send_item(tssp_pkg::CMD_TICK, 8'hA5, 8'h5A);
    endtask

    task automatic test_period_lowered();
        set_config(16'hFFFF, 16'd1, 8'd0);
        repeat (5) send_item(tssp_pkg::CMD_TICK, 8'h00, 8'h00);
        // counter now sits above the new top, so the next tick wraps
        set_config(16'd2, 16'd1, 8'd0);
        repeat (4) send_item(tssp_pkg::CMD_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_unmapped_register();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_beat(CFG_UNMAPPED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_item(tssp_pkg::CMD_SET_ANGLE, 8'd5, 8'd1);
        repeat (3) send_item(tssp_pkg::CMD_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_random_phases();
        int unsigned        sel;
        logic [CNT_W-1:0]   period;
        logic [PULSE_W-1:0] min_pulse;
        logic [STEP_W-1:0]  step;
        for (int phase = 0; phase < 8; phase++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      period = '0;
            else if (sel == 1) period = CNT_W'($urandom_range(200, 65535));
            else               period = CNT_W'($urandom_range(1, 24));
            min_pulse = PULSE_W'($urandom_range(0, 30));
            if ($urandom_range(0, 7) == 0) min_pulse = PULSE_W'($urandom);
            step = STEP_W'($urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0) step = STEP_W'($urandom);
            set_config(period, min_pulse, step);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat (150) send_random_beat();
        end
    endtask

    task automatic test_backpressure();
        set_config(16'd6, 16'd2, 8'd1);
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 64;
        repeat (40) send_random_beat();
        // pause the sender until every result is back
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) send_random_beat();
    endtask

    task automatic test_full_rate();
        set_config(16'd12, 16'd3, 8'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (260) send_random_beat();
    endtask

    // Sink: long hold-offs on request, short random stalls when rx_idle_on is set.
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Capture at the falling edge, compare once the taking edge has passed.
    initial begin : result_check
        t_servo_out got;
        t_servo_out want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.pins       = m_axis_tdata;
                got.slot_start = m_axis_tuser[0];
                got.accepted   = m_axis_tuser[1];
                @(posedge i_clk);
                if (pending_levels.size() == 0) begin
                    note_fault("unexpected beat", '0, got);
                end else begin
                    want = pending_levels.pop_front();
                    if (got.pins !== want.pins || got.slot_start !== want.slot_start ||
                        got.accepted !== want.accepted)
                        note_fault("mismatch", want, got);
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("time_sliced_servo_pwm regression: fail");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        fault_count   = 0;
        hold_request  = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        servo_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_period_extremes();
        test_period_lowered();
        test_unmapped_register();
        test_random_phases();
        test_backpressure();
        test_full_rate();

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0 && pending_levels.size() == 0) begin
            $display("time_sliced_servo_pwm regression: pass");
        end else begin
            $display("time_sliced_servo_pwm regression: fail");
        end
        $finish;
    end

endmodule
